[sv/bitmap_run_allocator_macros.svh]
// assertion macros for the bitmap run allocator
`ifndef BITMAP_RUN_ALLOCATOR_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define BRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/bra_pkg.sv]
// shared constants, types and helpers of the bitmap run allocator
`timescale 1ns / 1ps

package bra_pkg;

  localparam int MAP_BITS      = 1024;
  localparam int WORD_W        = 16;
  localparam int WORDS         = MAP_BITS / WORD_W;
  localparam int WADDR_W       = $clog2(WORDS);
  localparam int BIT_W         = $clog2(WORD_W);
  localparam int FUNC_W        = 3;
  localparam int IDX_W         = 10;
  localparam int CNT_W         = 11;
  localparam int LEN_W         = $clog2(MAP_BITS) + 1;
  localparam int CFG_W         = 8;
  localparam int MAP_BYTES_MAX = MAP_BITS / 8;

  localparam logic [CFG_W-1:0] MAP_BYTES_RESET = CFG_W'(128);

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_ONES = {WORD_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_TEST      = 3'd0,
    FN_SET       = 3'd1,
    FN_CLEAR     = 3'd2,
    FN_ALLOC     = 3'd3,
    FN_CLEAR_ALL = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT_RD,
    S_BIT_OP,
    S_SCAN_PRIME,
    S_SCAN,
    S_MARK_PRIME,
    S_MARK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
    logic [LEN_W-1:0] run_out;
  } scan_res_t;

  // active map length in blocks, saturated at the map size
  function automatic logic [LEN_W-1:0] len_of(input logic [CFG_W-1:0] mb);
    logic [LEN_W-1:0] len;
    if (int'(mb) > MAP_BYTES_MAX) len = LEN_W'(MAP_BITS);
    else len = LEN_W'({mb, 3'b000});
    return len;
  endfunction

endpackage

[sv/bra_req_if.sv]
// request channel: valid, ready and one request
`timescale 1ns / 1ps

interface bra_req_if import bra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  index;
  logic [CNT_W-1:0]  count;

  modport source(output valid, func, index, count, input ready);
  modport sink(input valid, func, index, count, output ready);
endinterface

[sv/bra_rsp_if.sv]
// response channel: valid, ready and one result
`timescale 1ns / 1ps

interface bra_rsp_if import bra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_set;
  logic             ok;
  logic [IDX_W-1:0] start_res;

  modport source(output valid, bit_set, ok, start_res, input ready);
  modport sink(input valid, bit_set, ok, start_res, output ready);
endinterface

[sv/bra_map_mem.sv]
// allocation map memory with per-word valid flags and registered read
`timescale 1ns / 1ps

module bra_map_mem import bra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [WADDR_W-1:0] rd_addr,
  output word_t              rd_data,
  input  logic               wr_en,
  input  logic [WADDR_W-1:0] wr_addr,
  input  word_t              wr_data,
  input  logic               clr_all
);

  word_t            mem [WORDS];
  logic [WORDS-1:0] word_valid;
  word_t            rdata;
  logic             rvalid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      word_valid <= '0;
      rvalid     <= 1'b0;
    end else begin
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      rvalid <= word_valid[rd_addr];
    end
  end

  // a word never written since clear reads as free
  assign rd_data = rvalid ? rdata : '0;

endmodule

[sv/bra_run_scan.sv]
// one map word of the first-fit search: hit position and carried run
`timescale 1ns / 1ps

module bra_run_scan import bra_pkg::*; (
  input  word_t            word,
  input  logic [LEN_W-1:0] run,
  input  logic [CNT_W-1:0] cnt,
  input  logic             tail,
  input  logic [BIT_W-1:0] tail_hi,
  output scan_res_t        res
);

  always_comb begin
    logic [WORD_W-1:0] hit_vec;
    word_t             below;
    logic [CNT_W-1:0]  jp1;
    logic [BIT_W-1:0]  lo;
    logic [BIT_W-1:0]  top;
    logic              found;

    hit_vec = '0;
    below   = '0;
    jp1     = '0;
    lo      = '0;
    top     = '0;
    found   = 1'b0;
    res     = '0;

    for (int j = 0; j < WORD_W; j++) begin
      jp1   = CNT_W'(j + 1);
      below = word & (WORD_ONES >> (WORD_W - 1 - j));
      if (cnt <= jp1) begin
        lo         = BIT_W'(jp1 - cnt);
        hit_vec[j] = ((below >> lo) == '0);
      end else begin
        hit_vec[j] = (below == '0) && (run >= LEN_W'(cnt - jp1));
      end
      if (tail && (BIT_W'(j) > tail_hi)) begin
        hit_vec[j] = 1'b0;
      end
    end

    for (int j = 0; j < WORD_W; j++) begin
      if (!found && hit_vec[j]) begin
        res.pos = BIT_W'(j);
        found   = 1'b1;
      end
    end
    res.hit = found;

    for (int k = 0; k < WORD_W; k++) begin
      if (word[k]) top = BIT_W'(k);
    end
    if (word == '0) res.run_out = run + LEN_W'(WORD_W);
    else res.run_out = LEN_W'(BIT_W'(WORD_W - 1) - top);
  end

endmodule

[sv/bitmap_run_allocator.sv]
// first-fit bitmap run allocator top level
// usage:
//   req carries one request (func, index, count) per transaction; rsp returns
//   exactly one result (bit_set, ok, start_res) for each request, in order.
//   cfg_we with cfg_wdata writes map_bytes, the number of map bytes in use.
// timing:
//   one request is in work at a time; req.ready is high while no request is
//   in work, also while an earlier result still waits in the rsp register.
//   test, set and clear: S_BIT_RD reads the word, S_BIT_OP tests or writes it,
//   S_RESP registers the result; out-of-range, clear-all, failed precheck: S_RESP only.
//   allocate: the map is read 16 bits per cycle over one memory read port;
//   S_SCAN_PRIME starts the read, S_SCAN searches word by word up to the hit word
//   (at most 64 words), then S_MARK_PRIME and S_MARK mark the words of the run,
//   and S_RESP registers the result; a full miss searches up to the last active word.
// reset:
//   rst clears the map at once through per-word valid flags, sets map_bytes
//   to 128 and empties the rsp register; no clearing pass is needed.
// stall:
//   a result that cannot enter the rsp register holds the request in work;
//   the rsp payload stays fixed until the transaction completes.
`timescale 1ns / 1ps
`include "bitmap_run_allocator_macros.svh"

module bitmap_run_allocator import bra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bra_req_if.sink          req,
  bra_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  state_t             state, state_next;
  logic [CFG_W-1:0]   map_bytes;
  func_t              func_q, func_q_next;
  logic [IDX_W-1:0]   idx_q, idx_q_next;
  logic [CNT_W-1:0]   cnt_q, cnt_q_next;
  logic [IDX_W-1:0]   lenm1_q, lenm1_q_next;
  logic [WADDR_W-1:0] addr, addr_next;
  logic [WADDR_W-1:0] rword_addr;
  logic [LEN_W-1:0]   run, run_next;
  logic [IDX_W-1:0]   start_q, start_q_next;
  logic [IDX_W-1:0]   end_q, end_q_next;
  logic               res_bit, res_bit_next;
  logic               res_ok, res_ok_next;
  logic [IDX_W-1:0]   res_start, res_start_next;
  logic               rsp_valid;
  logic               rsp_load;

  logic               wr_en;
  word_t              wr_data;
  word_t              rd_data;
  logic               clr_all;
  logic [LEN_W-1:0]   len_cur;
  logic [LEN_W-1:0]   len_cur_m1;
  logic [WADDR_W-1:0] last_w;
  scan_res_t          scan;
  logic [IDX_W-1:0]   hit_i;
  logic [IDX_W-1:0]   start_calc;
  logic [BIT_W-1:0]   mark_lo;
  logic [BIT_W-1:0]   mark_hi;
  word_t              mark_mask;
  word_t              bit_mask;

  assign len_cur    = len_of(map_bytes);
  assign len_cur_m1 = len_cur - LEN_W'(1);
  assign last_w     = lenm1_q[IDX_W-1:BIT_W];

  bra_map_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (rword_addr),
    .wr_data (wr_data),
    .clr_all (clr_all)
  );

  bra_run_scan u_scan (
    .word    (rd_data),
    .run     (run),
    .cnt     (cnt_q),
    .tail    (rword_addr == last_w),
    .tail_hi (lenm1_q[BIT_W-1:0]),
    .res     (scan)
  );

  assign hit_i      = {rword_addr, scan.pos};
  assign start_calc = IDX_W'(({1'b0, hit_i} + LEN_W'(1)) - LEN_W'(cnt_q));
  assign mark_lo    = (rword_addr == start_q[IDX_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
  assign mark_hi    = (rword_addr == end_q[IDX_W-1:BIT_W]) ? end_q[BIT_W-1:0]
                                                           : BIT_W'(WORD_W - 1);
  assign mark_mask  = (WORD_ONES << mark_lo) & (WORD_ONES >> (BIT_W'(WORD_W - 1) - mark_hi));
  assign bit_mask   = word_t'(1) << idx_q[BIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      map_bytes <= MAP_BYTES_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        map_bytes <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_q     <= func_q_next;
    idx_q      <= idx_q_next;
    cnt_q      <= cnt_q_next;
    lenm1_q    <= lenm1_q_next;
    addr       <= addr_next;
    rword_addr <= addr;
    run        <= run_next;
    start_q    <= start_q_next;
    end_q      <= end_q_next;
    res_bit    <= res_bit_next;
    res_ok     <= res_ok_next;
    res_start  <= res_start_next;
    if (rsp_load) begin
      rsp.bit_set   <= res_bit;
      rsp.ok        <= res_ok;
      rsp.start_res <= res_start;
    end
  end

  assign rsp.valid = rsp_valid;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    func_q_next    = func_q;
    idx_q_next     = idx_q;
    cnt_q_next     = cnt_q;
    lenm1_q_next   = lenm1_q;
    addr_next      = addr;
    run_next       = run;
    start_q_next   = start_q;
    end_q_next     = end_q;
    res_bit_next   = res_bit;
    res_ok_next    = res_ok;
    res_start_next = res_start;
    wr_en          = 1'b0;
    wr_data        = rd_data;
    clr_all        = 1'b0;
    rsp_load       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          func_q_next    = func_t'(req.func);
          idx_q_next     = req.index;
          cnt_q_next     = req.count;
          lenm1_q_next   = len_cur_m1[IDX_W-1:0];
          res_bit_next   = 1'b0;
          res_ok_next    = 1'b0;
          res_start_next = '0;
          state_next     = S_RESP;
          unique case (func_t'(req.func))
            FN_TEST: begin
              if (LEN_W'(req.index) < len_cur) begin
                addr_next  = req.index[IDX_W-1:BIT_W];
                state_next = S_BIT_RD;
              end else begin
                res_ok_next = 1'b1;
              end
            end
            FN_SET, FN_CLEAR: begin
              if (LEN_W'(req.index) < len_cur) begin
                addr_next  = req.index[IDX_W-1:BIT_W];
                state_next = S_BIT_RD;
              end
            end
            FN_ALLOC: begin
              if ((req.count != '0) && (LEN_W'(req.count) <= len_cur)) begin
                addr_next  = '0;
                run_next   = '0;
                state_next = S_SCAN_PRIME;
              end
            end
            FN_CLEAR_ALL: begin
              clr_all     = 1'b1;
              res_ok_next = 1'b1;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_BIT_RD: begin
        state_next = S_BIT_OP;
      end
      S_BIT_OP: begin
        res_ok_next = 1'b1;
        priority if (func_q == FN_TEST) begin
          res_bit_next = |(rd_data & bit_mask);
        end else if (func_q == FN_SET) begin
          wr_en   = 1'b1;
          wr_data = rd_data | bit_mask;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~bit_mask;
        end
        state_next = S_RESP;
      end
      S_SCAN_PRIME: begin
        addr_next  = addr + WADDR_W'(1);
        state_next = S_SCAN;
      end
      S_SCAN: begin
        addr_next = addr + WADDR_W'(1);
        run_next  = scan.run_out;
        if (scan.hit) begin
          start_q_next = start_calc;
          end_q_next   = hit_i;
          addr_next    = start_calc[IDX_W-1:BIT_W];
          state_next   = S_MARK_PRIME;
        end else if (rword_addr == last_w) begin
          state_next = S_RESP;
        end
      end
      S_MARK_PRIME: begin
        addr_next  = addr + WADDR_W'(1);
        state_next = S_MARK;
      end
      S_MARK: begin
        wr_en     = 1'b1;
        wr_data   = rd_data | mark_mask;
        addr_next = addr + WADDR_W'(1);
        if (rword_addr == end_q[IDX_W-1:BIT_W]) begin
          res_ok_next    = 1'b1;
          res_start_next = start_q;
          state_next     = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BRA_ASSERT_NOW(a_scan_bound, state == S_SCAN, rword_addr <= last_w,
                  "search read past the last active word")
  `BRA_ASSERT_NOW(a_mark_span, state == S_MARK,
                  (rword_addr >= start_q[IDX_W-1:BIT_W]) && (rword_addr <= end_q[IDX_W-1:BIT_W]),
                  "marking wrote outside the allocated run")
  `BRA_ASSERT_NOW(a_alloc_fit, rsp_load && res_ok && (func_q == FN_ALLOC),
                  (LEN_W'(res_start) + LEN_W'(cnt_q)) <= (LEN_W'(lenm1_q) + LEN_W'(1)),
                  "allocated run extends beyond the active map")
  `BRA_ASSERT_NEXT(a_clear_all_resp,
                   (state == S_IDLE) && req.valid && (req.func == FN_CLEAR_ALL),
                   (state == S_RESP) && res_ok,
                   "clear-all did not go straight to response")

endmodule
